>>> rtl/core/conv2d_3x3_zero_pad_stream_core_defines.svh
// Assertion macros for the 3x3 convolution core.
`ifndef CONV2D_3X3_ZERO_PAD_STREAM_CORE_DEFINES_SVH
`define CONV2D_3X3_ZERO_PAD_STREAM_CORE_DEFINES_SVH

`ifndef NO_ASSERTIONS
// Property that must hold at every clock edge outside reset.
`define C2DZP_ASSERT(name, prop, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);
// Condition in the cycle after a trigger, outside reset.
`define C2DZP_ASSERT_NEXT(name, pre, post, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error(msg);
`else
`define C2DZP_ASSERT(name, prop, msg)
`define C2DZP_ASSERT_NEXT(name, pre, post, msg)
`endif

`endif

>>> rtl/core/c2d3zp_pkg.sv
// Types, constants and helpers for the 3x3 zero-padded convolution core.
package c2d3zp_pkg;

    localparam int PIX_BITS       = 8;
    localparam int COEF_BITS      = 16;
    localparam int KTAPS          = 3;
    localparam int KROW_BITS      = KTAPS * COEF_BITS;
    localparam int CFG_IDX_BITS   = 3;
    localparam int CFG_DATA_BITS  = 48;
    localparam int CFG_WIDTH_BITS = 6;
    localparam int ROW_BITS       = 12;
    localparam int ROWX_BITS      = ROW_BITS + 1;
    localparam int RES_BITS       = 28;
    localparam int PROD_BITS      = PIX_BITS + 1 + COEF_BITS;
    localparam int RSUM_BITS      = PROD_BITS + 2;
    localparam int SUM_BITS       = RSUM_BITS + 2;

    typedef logic [PIX_BITS-1:0]             t_pix;
    typedef logic signed [COEF_BITS-1:0]     t_coef;
    typedef logic [KROW_BITS-1:0]            t_krow;
    typedef logic [CFG_IDX_BITS-1:0]         t_cfg_idx;
    typedef logic [CFG_DATA_BITS-1:0]        t_cfg_data;
    typedef logic [CFG_WIDTH_BITS-1:0]       t_width;
    typedef logic [ROW_BITS-1:0]             t_row;
    typedef logic [ROWX_BITS-1:0]            t_rowx;
    typedef logic signed [RES_BITS-1:0]      t_result;
    typedef logic signed [PROD_BITS-1:0]     t_prod;
    typedef logic signed [RSUM_BITS-1:0]     t_rsum;
    typedef logic signed [SUM_BITS-1:0]      t_sum;
    typedef logic [1:0]                      t_slot;

    // Configuration register indexes.
    localparam t_cfg_idx CFG_IMAGE_WIDTH  = 3'd0;
    localparam t_cfg_idx CFG_IMAGE_HEIGHT = 3'd1;
    localparam t_cfg_idx CFG_KERN_TOP     = 3'd2;
    localparam t_cfg_idx CFG_KERN_MIDDLE  = 3'd3;
    localparam t_cfg_idx CFG_KERN_BOTTOM  = 3'd4;

    localparam t_width WIDTH_RESET  = 6'd32;
    localparam t_row   HEIGHT_RESET = 12'd32;
    localparam t_krow  KTOP_RESET   = 48'h0000_0000_0000;
    localparam t_krow  KMID_RESET   = 48'h0000_0001_0000;
    localparam t_krow  KBOT_RESET   = 48'h0000_0000_0000;

    localparam t_slot SLOT_FIRST = 2'd0;
    localparam t_slot SLOT_LAST  = 2'd2;

    typedef enum logic [3:0] {
        S_ACCEPT = 4'b0001,
        S_PAD    = 4'b0010,
        S_FLUSH  = 4'b0100,
        S_FPAD   = 4'b1000
    } t_state;

    // Line store slots rotate through row number modulo three.
    function automatic t_slot slot_inc(input t_slot s);
        return (s == SLOT_LAST) ? SLOT_FIRST : t_slot'(s + 2'd1);
    endfunction

    function automatic t_slot slot_dec(input t_slot s);
        return (s == SLOT_FIRST) ? SLOT_LAST : t_slot'(s - 2'd1);
    endfunction

endpackage

>>> rtl/core/conv2d_3x3_zero_pad_stream_core.sv
// Streaming 3x3 zero-padded 2D correlation over 8-bit raster pixels.
//
// Pixels arrive in raster order on the input channel, one per transfer, and the
// core returns a same-size correlation with a signed 3x3 kernel (no flip),
// treating neighbors outside the image as zero. Pixel (r,c) releases result
// (r-1,c-1); the last pixel of a row also yields (r-1,W-1), and the last pixel
// of the frame also yields the whole last row. Pixels within a row stream at
// one pixel per clock while the output does not stall. From the second row on,
// the last pixel of a row also issues a zero column past the right edge, and
// the last pixel of the frame issues one flush column per bottom-row pixel and
// a final zero column, because every result passes the single result register
// and each flushed column is one read of the line store. The line store is
// three banks of MAX_WIDTH pixels, one per row modulo three, with two registered
// read ports; nine products are formed in parallel, then row sums, then the
// final sum. When the output stalls, the whole pipeline holds and the input
// stalls with it. Configuration must be written through the plain write port
// only while no pixel is in flight; the core itself does not enforce this.
// Image width is clamped to 1..MAX_WIDTH and a height of zero acts as one.
`include "conv2d_3x3_zero_pad_stream_core_defines.svh"

module conv2d_3x3_zero_pad_stream_core #(
    parameter int MAX_WIDTH = 32,
    localparam int COL_BITS = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_wr_en,
    input  c2d3zp_pkg::t_cfg_idx  i_cfg_index,
    input  c2d3zp_pkg::t_cfg_data i_cfg_data,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  c2d3zp_pkg::t_pix      i_pixel,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output c2d3zp_pkg::t_result   o_result,
    output c2d3zp_pkg::t_row      o_out_row,
    output logic [COL_BITS-1:0]   o_out_col,
    output logic                  o_last_of_run,
    output logic                  o_frame_done
);
    import c2d3zp_pkg::*;

    localparam t_width MAX_W = CFG_WIDTH_BITS'(MAX_WIDTH);

    // Position and flags of one result as it travels down the pipeline.
    typedef struct packed {
        t_row                row;
        logic [COL_BITS-1:0] col;
        logic                last;
        logic                done;
    } t_meta;

    // ------------------------------------------------------------------
    // Configuration registers.
    // ------------------------------------------------------------------
    t_width r_cfg_width;
    t_row   r_cfg_height;
    t_krow  r_kern [KTAPS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_width  <= WIDTH_RESET;
            r_cfg_height <= HEIGHT_RESET;
            r_kern[0]    <= KTOP_RESET;
            r_kern[1]    <= KMID_RESET;
            r_kern[2]    <= KBOT_RESET;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                CFG_IMAGE_WIDTH:  r_cfg_width  <= i_cfg_data[CFG_WIDTH_BITS-1:0];
                CFG_IMAGE_HEIGHT: r_cfg_height <= i_cfg_data[ROW_BITS-1:0];
                CFG_KERN_TOP:     r_kern[0]    <= i_cfg_data[KROW_BITS-1:0];
                CFG_KERN_MIDDLE:  r_kern[1]    <= i_cfg_data[KROW_BITS-1:0];
                CFG_KERN_BOTTOM:  r_kern[2]    <= i_cfg_data[KROW_BITS-1:0];
                default: ;
            endcase
        end
    end

    // Effective frame size: width clamped to 1..MAX_WIDTH, height at least one.
    t_width              w_eff;
    t_row                h_eff;
    logic [COL_BITS-1:0] w_last_col;

    always_comb begin
        if (r_cfg_width == '0) begin
            w_eff = CFG_WIDTH_BITS'(1);
        end else if (r_cfg_width > MAX_W) begin
            w_eff = MAX_W;
        end else begin
            w_eff = r_cfg_width;
        end
        h_eff      = (r_cfg_height == '0) ? ROW_BITS'(1) : r_cfg_height;
        w_last_col = COL_BITS'(w_eff - CFG_WIDTH_BITS'(1));
    end

    // ------------------------------------------------------------------
    // Input position and issue sequencer.
    // ------------------------------------------------------------------
    t_state              r_state;
    t_state              n_state;
    logic [COL_BITS-1:0] r_flush_col;
    logic [COL_BITS-1:0] n_flush_col;
    t_row                r_in_row;
    logic [COL_BITS-1:0] r_in_col;
    t_slot               r_in_slot;
    t_row                r_seq_row;
    t_slot               r_seq_slot;
    logic                r_seq_fe;
    logic                r_out_valid;

    logic                adv;
    logic                in_accept;
    logic                wrap_col;
    t_rowx               row_a;
    t_slot               slot_a;
    t_row                cur_row;
    logic [COL_BITS-1:0] cur_col;
    t_slot               cur_slot;
    logic                row_end;
    logic                frame_end;

    // The pipeline moves whenever the result register is free or being taken.
    assign adv        = !r_out_valid || !i_out_stall;
    assign o_in_stall = !adv || (r_state != S_ACCEPT);
    assign in_accept  = i_in_valid && !o_in_stall;

    // A position left outside the frame by a size change starts a new row or frame.
    always_comb begin
        wrap_col = CFG_WIDTH_BITS'(r_in_col) >= w_eff;
        row_a    = wrap_col ? (ROWX_BITS'(r_in_row) + ROWX_BITS'(1)) : ROWX_BITS'(r_in_row);
        slot_a   = wrap_col ? slot_inc(r_in_slot) : r_in_slot;
        if (row_a >= ROWX_BITS'(h_eff)) begin
            cur_row  = '0;
            cur_slot = SLOT_FIRST;
        end else begin
            cur_row  = row_a[ROW_BITS-1:0];
            cur_slot = slot_a;
        end
        cur_col   = wrap_col ? '0 : r_in_col;
        row_end   = (cur_col == w_last_col);
        frame_end = row_end && (cur_row == h_eff - ROW_BITS'(1));
    end

    // At most one column operation is issued per advancing cycle: a pixel column, a
    // zero column past the right edge, or a flush column read from the store.
    logic                op_valid;
    logic                op_pad;
    logic                op_emit;
    t_pix                op_bot;
    t_slot               op_tslot;
    t_slot               op_mslot;
    t_meta               op_meta;
    logic [COL_BITS-1:0] mem_addr;

    always_comb begin
        n_state     = r_state;
        n_flush_col = r_flush_col;
        op_valid    = 1'b0;
        op_pad      = 1'b0;
        op_emit     = 1'b0;
        op_bot      = '0;
        op_tslot    = slot_dec(r_seq_slot);
        op_mslot    = r_seq_slot;
        op_meta     = '0;
        mem_addr    = r_flush_col;
        case (r_state)
            S_ACCEPT: begin
                mem_addr = cur_col;
                op_tslot = slot_dec(slot_dec(cur_slot));
                op_mslot = slot_dec(cur_slot);
                if (in_accept) begin
                    op_valid     = 1'b1;
                    op_emit      = (cur_row != '0) && (cur_col != '0);
                    op_bot       = i_pixel;
                    op_meta.row  = cur_row - ROW_BITS'(1);
                    op_meta.col  = cur_col - COL_BITS'(1);
                    op_meta.last = !row_end;
                    if (row_end && (cur_row != '0)) begin
                        n_state = S_PAD;
                    end else if (frame_end) begin
                        n_state = S_FLUSH;
                    end
                end
            end
            S_PAD: begin
                op_valid     = 1'b1;
                op_pad       = 1'b1;
                op_emit      = 1'b1;
                op_meta.row  = r_seq_row - ROW_BITS'(1);
                op_meta.col  = w_last_col;
                op_meta.last = !r_seq_fe;
                n_state      = r_seq_fe ? S_FLUSH : S_ACCEPT;
            end
            S_FLUSH: begin
                op_valid    = 1'b1;
                op_emit     = (r_flush_col != '0);
                op_meta.row = r_seq_row;
                op_meta.col = r_flush_col - COL_BITS'(1);
                if (r_flush_col == w_last_col) begin
                    n_state     = S_FPAD;
                    n_flush_col = '0;
                end else begin
                    n_flush_col = r_flush_col + COL_BITS'(1);
                end
            end
            S_FPAD: begin
                op_valid     = 1'b1;
                op_pad       = 1'b1;
                op_emit      = 1'b1;
                op_meta.row  = r_seq_row;
                op_meta.col  = w_last_col;
                op_meta.last = 1'b1;
                op_meta.done = 1'b1;
                n_state      = S_ACCEPT;
            end
            default: begin
                n_state = S_ACCEPT;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_ACCEPT;
            r_flush_col <= '0;
            r_in_row    <= '0;
            r_in_col    <= '0;
            r_in_slot   <= SLOT_FIRST;
            r_seq_row   <= '0;
            r_seq_slot  <= SLOT_FIRST;
            r_seq_fe    <= 1'b0;
        end else begin
            if (adv) begin
                r_state     <= n_state;
                r_flush_col <= n_flush_col;
            end
            if (in_accept) begin
                r_seq_row  <= cur_row;
                r_seq_slot <= cur_slot;
                r_seq_fe   <= frame_end;
                if (frame_end) begin
                    r_in_row  <= '0;
                    r_in_col  <= '0;
                    r_in_slot <= SLOT_FIRST;
                end else if (row_end) begin
                    r_in_row  <= cur_row + ROW_BITS'(1);
                    r_in_col  <= '0;
                    r_in_slot <= slot_inc(cur_slot);
                end else begin
                    r_in_row  <= cur_row;
                    r_in_col  <= cur_col + COL_BITS'(1);
                    r_in_slot <= cur_slot;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Line store: one bank per row modulo three, one write port and two
    // registered read ports that fetch the upper and middle window rows.
    // ------------------------------------------------------------------
    t_pix r_line [KTAPS][MAX_WIDTH];
    t_pix r_rd_top;
    t_pix r_rd_mid;

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_line[cur_slot][cur_col] <= i_pixel;
        end
        if (adv) begin
            r_rd_top <= r_line[op_tslot][mem_addr];
            r_rd_mid <= r_line[op_mslot][mem_addr];
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: operation waits for its read data.
    // ------------------------------------------------------------------
    logic  r_s1_valid;
    logic  r_s1_pad;
    logic  r_s1_emit;
    t_pix  r_s1_bot;
    t_meta r_s1_meta;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (adv) begin
            r_s1_valid <= op_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s1_pad  <= op_pad;
            r_s1_emit <= op_emit;
            r_s1_bot  <= op_bot;
            r_s1_meta <= op_meta;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: 3x3 window. Each operation shifts one column in from the
    // right; border masks are worked out from the result position.
    // ------------------------------------------------------------------
    logic                  r_s2_valid;
    t_pix                  r_win [KTAPS][KTAPS];
    t_meta                 r_s2_meta;
    logic [KTAPS-1:0]      r_s2_ok_row;
    logic [KTAPS-1:0]      r_s2_ok_col;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (adv) begin
            r_s2_valid <= r_s1_valid && r_s1_emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && r_s1_valid) begin
            for (int i = 0; i < KTAPS; i++) begin
                r_win[i][0] <= r_win[i][1];
                r_win[i][1] <= r_win[i][2];
            end
            r_win[0][2] <= r_s1_pad ? '0 : r_rd_top;
            r_win[1][2] <= r_s1_pad ? '0 : r_rd_mid;
            r_win[2][2] <= r_s1_bot;
            r_s2_meta   <= r_s1_meta;
            r_s2_ok_row <= {(ROWX_BITS'(r_s1_meta.row) + ROWX_BITS'(1)) < ROWX_BITS'(h_eff),
                            1'b1,
                            r_s1_meta.row != '0};
            r_s2_ok_col <= {r_s1_meta.col != w_last_col, 1'b1, r_s1_meta.col != '0};
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: nine products in parallel.
    // ------------------------------------------------------------------
    logic signed [PIX_BITS:0] px   [KTAPS][KTAPS];
    t_coef                    cf   [KTAPS][KTAPS];
    t_prod                    prod [KTAPS][KTAPS];

    always_comb begin
        for (int i = 0; i < KTAPS; i++) begin
            for (int j = 0; j < KTAPS; j++) begin
                px[i][j]   = (r_s2_ok_row[i] && r_s2_ok_col[j]) ?
                             $signed({1'b0, r_win[i][j]}) : '0;
                cf[i][j]   = r_kern[i][COEF_BITS*j +: COEF_BITS];
                prod[i][j] = t_prod'(px[i][j]) * t_prod'(cf[i][j]);
            end
        end
    end

    logic  r_s3_valid;
    t_prod r_s3_prod [KTAPS][KTAPS];
    t_meta r_s3_meta;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_valid <= 1'b0;
        end else if (adv) begin
            r_s3_valid <= r_s2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && r_s2_valid) begin
            r_s3_prod <= prod;
            r_s3_meta <= r_s2_meta;
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: one sum per kernel row.
    // ------------------------------------------------------------------
    logic  r_s4_valid;
    t_rsum r_s4_rsum [KTAPS];
    t_meta r_s4_meta;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s4_valid <= 1'b0;
        end else if (adv) begin
            r_s4_valid <= r_s3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && r_s3_valid) begin
            for (int i = 0; i < KTAPS; i++) begin
                r_s4_rsum[i] <= t_rsum'(r_s3_prod[i][0]) + t_rsum'(r_s3_prod[i][1])
                              + t_rsum'(r_s3_prod[i][2]);
            end
            r_s4_meta <= r_s3_meta;
        end
    end

    // ------------------------------------------------------------------
    // Result register: final sum, fits the result width exactly.
    // ------------------------------------------------------------------
    t_sum    sum_all;
    t_result r_out_result;
    t_meta   r_out_meta;

    assign sum_all = t_sum'(r_s4_rsum[0]) + t_sum'(r_s4_rsum[1]) + t_sum'(r_s4_rsum[2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= r_s4_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && r_s4_valid) begin
            r_out_result <= t_result'(sum_all[RES_BITS-1:0]);
            r_out_meta   <= r_s4_meta;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_result      = r_out_result;
    assign o_out_row     = r_out_meta.row;
    assign o_out_col     = r_out_meta.col;
    assign o_last_of_run = r_out_meta.last;
    assign o_frame_done  = r_out_meta.done;

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------
    `C2DZP_ASSERT(a_flush_col_in_row, (r_state != S_FLUSH) || (r_flush_col <= w_last_col), "flush column beyond image width")
    `C2DZP_ASSERT_NEXT(a_frame_end_flushes, in_accept && frame_end, (r_state == S_PAD) || (r_state == S_FLUSH), "frame end pixel did not start the flush")
    `C2DZP_ASSERT_NEXT(a_fpad_returns, (r_state == S_FPAD) && adv, r_state == S_ACCEPT, "flush did not return to accepting pixels")
    `C2DZP_ASSERT(a_done_is_last, !o_out_valid || !o_frame_done || o_last_of_run, "frame done result not marked last")
    `C2DZP_ASSERT(a_slot_range, (r_in_slot != 2'd3) && (r_seq_slot != 2'd3), "line store slot out of range")

endmodule

>>> tb/conv2d_3x3_zero_pad_stream_core_tb.sv
// Self-checking testbench for the streaming 3x3 zero-padded convolution core.
module conv2d_3x3_zero_pad_stream_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import c2d3zp_pkg::*;

    localparam int MAX_W         = 32;
    localparam int COL_W         = $clog2(MAX_W);
    localparam int CLK_HALF      = 4;
    // Worst case drain: a full-width flush plus the five-stage arithmetic pipe.
    localparam int SETTLE_CYCLES = MAX_W + 16;
    // Cycles without any transfer on either channel before the run is abandoned.
    localparam int QUIET_LIMIT   = 2000;

    localparam t_krow KROW_MOST_NEG = 48'h8000_8000_8000;
    localparam t_krow KROW_MOST_POS = 48'h7FFF_7FFF_7FFF;

    // One expected output pixel of the convolution.
    typedef struct {
        t_result          result;
        t_row             row;
        logic [COL_W-1:0] col;
        logic             last;
        logic             done;
    } t_conv_out;

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_cfg_wr_en = 1'b0;
    t_cfg_idx              i_cfg_index = CFG_IMAGE_WIDTH;
    t_cfg_data             i_cfg_data  = '0;
    logic                  i_in_valid  = 1'b0;
    logic                  o_in_stall;
    t_pix                  i_pixel     = '0;
    logic                  o_out_valid;
    logic                  i_out_stall = 1'b0;
    t_result               o_result;
    t_row                  o_out_row;
    logic [COL_W-1:0]      o_out_col;
    logic                  o_last_of_run;
    logic                  o_frame_done;

    // Mirror of the core: line stores, raster position and register contents.
    t_pix      line_buf [3*MAX_W];
    int        pos_row = 0;
    int        pos_col = 0;
    t_width    cfg_width  = WIDTH_RESET;
    t_row      cfg_height = HEIGHT_RESET;
    t_krow     kern_row [3] = '{KTOP_RESET, KMID_RESET, KBOT_RESET};

    t_conv_out conv_out_q [$];

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int error_count    = 0;
    int quiet_cycles   = 0;
    int pixels_sent    = 0;
    int results_seen   = 0;
    int frames_done    = 0;
    int programmings   = 0;

    always #(CLK_HALF) i_clk = ~i_clk;

    conv2d_3x3_zero_pad_stream_core #(
        .MAX_WIDTH(MAX_W)
    ) uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_pixel       (i_pixel),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_result      (o_result),
        .o_out_row     (o_out_row),
        .o_out_col     (o_out_col),
        .o_last_of_run (o_last_of_run),
        .o_frame_done  (o_frame_done)
    );

    // The width register is clamped to 1..MAX_W and a zero height acts as one.
    function automatic int active_width();
        int w;
        w = int'(cfg_width);
        if (w < 1) w = 1;
        if (w > MAX_W) w = MAX_W;
        return w;
    endfunction

    function automatic int active_height();
        return (cfg_height == '0) ? 1 : int'(cfg_height);
    endfunction

    // Correlation at (row,col) without a kernel flip; pixels outside the
    // active image count as zero.
    function automatic void push_conv_output(input int row, input int col, input int w,
                                             input int h, input bit last, input bit done);
        longint    acc;
        int        kr;
        int        kc;
        int        rr;
        int        cc;
        t_coef     k;
        t_conv_out item;
        acc = 0;
        for (kr = 0; kr < KTAPS; kr++) begin
            for (kc = 0; kc < KTAPS; kc++) begin
                rr = row + kr - 1;
                cc = col + kc - 1;
                if (rr >= 0 && cc >= 0 && rr < h && cc < w) begin
                    k = kern_row[kr][COEF_BITS*kc +: COEF_BITS];
                    acc += longint'(k) * longint'(line_buf[(rr % 3) * MAX_W + cc]);
                end
            end
        end
        item.result = acc[RES_BITS-1:0];
        item.row    = t_row'(row);
        item.col    = col[COL_W-1:0];
        item.last   = last;
        item.done   = done;
        conv_out_q.push_back(item);
    endfunction

    // Takes one accepted pixel, stores it and queues every output it releases.
    function automatic void advance_raster(input t_pix value);
        int w;
        int h;
        int r;
        int c;
        int k;
        bit row_end;
        bit frame_end;
        w = active_width();
        h = active_height();
        // A shrunk width moves the pixel to the next row, a shrunk height to row 0.
        if (pos_col >= w) begin
            pos_col = 0;
            pos_row++;
        end
        if (pos_row >= h) pos_row = 0;
        r = pos_row;
        c = pos_col;
        line_buf[(r % 3) * MAX_W + c] = value;
        row_end   = (c + 1 == w);
        frame_end = row_end && (r + 1 == h);
        if (r >= 1) begin
            if (c >= 1) push_conv_output(r - 1, c - 1, w, h, !row_end, 1'b0);
            if (row_end) push_conv_output(r - 1, w - 1, w, h, !frame_end, 1'b0);
        end
        if (frame_end) begin
            // The last pixel of the frame also flushes the whole bottom row.
            for (k = 0; k < w; k++) push_conv_output(r, k, w, h, k + 1 == w, k + 1 == w);
            pos_row = 0;
            pos_col = 0;
            frames_done++;
        end else if (row_end) begin
            pos_col = 0;
            pos_row++;
        end else begin
            pos_col++;
        end
    endfunction

    function automatic t_pix random_pixel();
        int sel;
        sel = $urandom_range(9);
        if (sel == 0) return '0;
        if (sel == 1) return '1;
        return t_pix'($urandom_range(255));
    endfunction

    function automatic t_krow random_kernel_row();
        case ($urandom_range(9))
            0: return KROW_MOST_NEG;
            1: return KROW_MOST_POS;
            2: return '0;
            3: return '1;
            default: return t_krow'({$urandom, $urandom});
        endcase
    endfunction

    // Register value with random garbage above the register's own width now and then.
    function automatic t_cfg_data with_junk(input int value, input int bits);
        t_cfg_data d;
        d = ($urandom_range(3) == 0) ? t_cfg_data'({$urandom, $urandom}) : '0;
        return ((d >> bits) << bits) | t_cfg_data'(value);
    endfunction

    // Waits until every queued output has arrived and the pipe has run dry.
    // Pixels of the first row release nothing, so the settle time is needed too.
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (conv_out_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Writes all five registers back to back once the core is idle.
    task automatic program_block(input t_cfg_data w, input t_cfg_data h, input t_krow k_top,
                                 input t_krow k_mid, input t_krow k_bot);
        t_cfg_idx  reg_order [5];
        t_cfg_data vals [5];
        int        i;
        reg_order = '{CFG_IMAGE_WIDTH, CFG_IMAGE_HEIGHT, CFG_KERN_TOP, CFG_KERN_MIDDLE,
                      CFG_KERN_BOTTOM};
        vals      = '{w, h, k_top, k_mid, k_bot};
        wait_drained();
        for (i = 0; i < 5; i++) begin
            i_cfg_wr_en <= 1'b1;
            i_cfg_index <= reg_order[i];
            i_cfg_data  <= vals[i];
            @(posedge i_clk);
            case (reg_order[i])
                CFG_IMAGE_WIDTH:  cfg_width   = vals[i][CFG_WIDTH_BITS-1:0];
                CFG_IMAGE_HEIGHT: cfg_height  = vals[i][ROW_BITS-1:0];
                CFG_KERN_TOP:     kern_row[0] = vals[i][KROW_BITS-1:0];
                CFG_KERN_MIDDLE:  kern_row[1] = vals[i][KROW_BITS-1:0];
                CFG_KERN_BOTTOM:  kern_row[2] = vals[i][KROW_BITS-1:0];
                default: ;
            endcase
        end
        i_cfg_wr_en <= 1'b0;
        programmings++;
    endtask

    // Presents one pixel and holds it until the core takes the transfer.
    // Valid is only lowered when the sender actually idles, so it is never
    // dropped and raised again within one time step.
    task automatic send_pixel(input t_pix value);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_pixel    <= value;
        do @(posedge i_clk); while (o_in_stall);
        pixels_sent++;
        advance_raster(value);
    endtask

    // One-pixel frames: zero width and zero height act as one, and only the
    // center tap sees the image.
    task automatic test_one_pixel_frames();
        program_block('0, '0, KROW_MOST_NEG, KROW_MOST_NEG, KROW_MOST_NEG);
        send_pixel(8'hFF);
        program_block(t_cfg_data'(1), '0, KROW_MOST_POS, KROW_MOST_POS, KROW_MOST_POS);
        send_pixel(8'hFF);
    endtask

    // A single column, where the row-end output is the only one, and a single
    // row, where only the frame flush produces outputs.
    task automatic test_thin_frames();
        program_block(t_cfg_data'(1), t_cfg_data'(3), random_kernel_row(),
                      random_kernel_row(), random_kernel_row());
        send_pixel(8'h00);
        send_pixel(8'hFF);
        send_pixel(8'h5A);
        program_block(t_cfg_data'(2), t_cfg_data'(1), random_kernel_row(),
                      random_kernel_row(), random_kernel_row());
        send_pixel(8'hFF);
        send_pixel(8'h00);
    endtask

    // Saturated 3x3 frames that drive the center sum to both ends of its range.
    task automatic test_extreme_sums();
        program_block(t_cfg_data'(3), t_cfg_data'(3), KROW_MOST_NEG, KROW_MOST_NEG,
                      KROW_MOST_NEG);
        repeat (9) send_pixel(8'hFF);
        program_block(t_cfg_data'(3), t_cfg_data'(3), KROW_MOST_POS, KROW_MOST_POS,
                      KROW_MOST_POS);
        repeat (9) send_pixel(8'hFF);
    endtask

    // Oversize width and the largest height, then both shrink mid-row so that
    // the next pixel lands past the new width and closes the frame.
    task automatic test_resize_mid_frame();
        program_block(t_cfg_data'(63), t_cfg_data'(4095), random_kernel_row(),
                      random_kernel_row(), random_kernel_row());
        send_pixel(random_pixel());
        send_pixel(random_pixel());
        program_block(t_cfg_data'(1), t_cfg_data'(2), random_kernel_row(),
                      random_kernel_row(), random_kernel_row());
        send_pixel(random_pixel());
    endtask

    // Random frames with random sizes and kernels. About a quarter are cut
    // short: the core is reprogrammed mid-frame with a smaller width or height
    // (never larger, so no line store entry is read before it is written).
    task automatic test_random_frames(input int n_pixels, input int send_pct,
                                      input int recv_pct);
        int first;
        int sel;
        int w;
        int h;
        int frame_len;
        int cut;
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        first = pixels_sent;
        while (pixels_sent - first < n_pixels) begin
            sel = $urandom_range(99);
            if (sel < 4) w = 0;
            else if (sel < 80) w = $urandom_range(1, 8);
            else if (sel < 88) w = $urandom_range(9, MAX_W - 1);
            else if (sel < 95) w = MAX_W;
            else w = $urandom_range(MAX_W + 1, 63);
            sel = $urandom_range(99);
            if (w > 8) h = $urandom_range(0, 2);
            else if (sel < 10) h = 0;
            else if (sel < 80) h = $urandom_range(1, 5);
            else h = $urandom_range(6, 12);
            program_block(with_junk(w, CFG_WIDTH_BITS), with_junk(h, ROW_BITS),
                          random_kernel_row(), random_kernel_row(), random_kernel_row());
            frame_len = active_width() * active_height();
            cut = 0;
            if (frame_len > 1 && $urandom_range(99) < 25) cut = $urandom_range(1, frame_len - 1);
            if (cut != 0) begin
                repeat (cut) send_pixel(random_pixel());
                sel = $urandom_range(2);
                w = (sel != 1) ? $urandom_range(1, active_width()) : int'(cfg_width);
                h = (sel != 0) ? $urandom_range(0, active_height()) : int'(cfg_height);
                program_block(t_cfg_data'(w), t_cfg_data'(h), random_kernel_row(),
                              random_kernel_row(), random_kernel_row());
            end
            // Keep streaming until the raster position wraps back to the origin.
            do send_pixel(random_pixel()); while (pos_row != 0 || pos_col != 0);
        end
    endtask

    // Output side: random stall, transfer checking and the quiet-cycle count.
    // Outputs are sampled at the edge, before any update of that edge lands.
    always @(posedge i_clk) begin : out_monitor
        t_conv_out want;
        i_out_stall <= i_rst_n && ($urandom_range(99) < recv_stall_pct);
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            results_seen++;
            if (conv_out_q.size() == 0) begin
                error_count++;
                if (error_count <= 10) begin
                    $display("unexpected output: result %0d at (%0d,%0d) last %0b done %0b",
                             o_result, o_out_row, o_out_col, o_last_of_run, o_frame_done);
                end
            end else begin
                want = conv_out_q.pop_front();
                if (o_result !== want.result || o_out_row !== want.row ||
                    o_out_col !== want.col || o_last_of_run !== want.last ||
                    o_frame_done !== want.done) begin
                    error_count++;
                    if (error_count <= 10) begin
                        $display("mismatch: expected %0d at (%0d,%0d) last %0b done %0b",
                                 want.result, want.row, want.col, want.last, want.done);
                        $display("          got      %0d at (%0d,%0d) last %0b done %0b",
                                 o_result, o_out_row, o_out_col, o_last_of_run,
                                 o_frame_done);
                    end
                end
            end
        end
    end

    // A hung handshake shows up as a long stretch with no transfer at all.
    initial begin : watchdog
        while (quiet_cycles < QUIET_LIMIT) @(posedge i_clk);
        $display("no transfer for %0d cycles, giving up", QUIET_LIMIT);
        $display("FAIL conv2d_3x3_zero_pad_stream_core");
        $finish;
    end

    initial begin : run
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed shapes run under the first idle mix.
        send_idle_pct  = 6;
        recv_stall_pct = 56;
        test_one_pixel_frames();
        test_thin_frames();
        test_extreme_sums();
        test_resize_mid_frame();

        // Random frames: sender eager and receiver busy, then the reverse,
        // then both sides at full rate.
        test_random_frames(115, 6, 56);
        test_random_frames(115, 56, 6);
        test_random_frames(115, 0, 0);

        wait_drained();
        $display("Streamed %0d pixels into %0d checked outputs over %0d complete frames.",
                 pixels_sent, results_seen, frames_done);
        $display("The core was reprogrammed %0d times, mid-frame shrinks included.",
                 programmings);
        if (error_count == 0 && conv_out_q.size() == 0) begin
            $display("PASS conv2d_3x3_zero_pad_stream_core");
        end else begin
            $display("%0d bad outputs, %0d expected outputs never arrived",
                     error_count, conv_out_q.size());
            $display("FAIL conv2d_3x3_zero_pad_stream_core");
        end
        $finish;
    end

endmodule

>>> conv2d_3x3_zero_pad_stream_core.f
+incdir+rtl/core
rtl/core/c2d3zp_pkg.sv
rtl/core/conv2d_3x3_zero_pad_stream_core.sv
tb/conv2d_3x3_zero_pad_stream_core_tb.sv
